// ===== hdl/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher unit.
// Depends on nothing; the top level and its RAM sizing take it in.
package rc4_pkg;

    localparam int SBOX_DEPTH = 256;
    localparam int BYTE_W     = 8;
    localparam int KEY_BYTES  = 16;

    typedef logic [0:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KEY_LOW  = 1'b0;
    localparam t_cfg_idx CFG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_in;
        logic              last_in;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              last_out;
    } t_out_beat;

endpackage

// ===== hdl/rc4_stream_cipher_unit.sv =====
// RC4 stream cipher unit: one byte in, one byte out, S-box in a 256x8 RAM.
// Depends on rc4_pkg (types, constants) and rc4_ram (S-box storage).
// Flow: an accepted beat passes S_PB, S_PC, S_PD and S_PE; its result is then held in
// the output register. A new beat is taken only once the last one is through, as its
// reads depend on each other through the one RAM port. The first beat after reset or
// after a last beat also waits for the key schedule: the identity fill, the swap steps
// (S_KA to S_KD for each S-box entry) and a restart step (S_PA).
// Reset (synchronous, active low) clears the key, both indices and the output,
// and arms the key schedule; the S-box RAM itself is not cleared.
module rc4_stream_cipher_unit #(
    parameter int KEY_LENGTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Data input channel.
    input  logic                i_valid,
    output logic                o_ready,
    input  rc4_pkg::t_in_beat   i_in,
    // Data output channel.
    output logic                o_valid,
    input  logic                i_ready,
    output rc4_pkg::t_out_beat  o_out,
    // Configuration write channel.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  rc4_pkg::t_cfg_idx   i_cfg_index,
    input  logic [63:0]         i_cfg_data
);

    import rc4_pkg::*;

    localparam int AW = $clog2(SBOX_DEPTH);
    // The key length is held to the range the two key registers can supply.
    localparam int KEY_LEN = (KEY_LENGTH < 1) ? 1 :
                             (KEY_LENGTH > KEY_BYTES) ? KEY_BYTES : KEY_LENGTH;
    localparam int KW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

    // The sequencer walks the key schedule (fill, then swap steps S_KA to S_KD)
    // and the per-byte keystream generation, all through one RAM port pair.
    typedef enum logic [3:0] {
        S_IDLE,  // waiting for a beat; also issues the read of S[i+1]
        S_INIT,  // identity fill of the S-box, one entry per cycle
        S_KA,    // schedule: read S[n]
        S_KB,    // schedule: update j, read S[j]
        S_KC,    // schedule: write S[n] = S[j]
        S_KD,    // schedule: write S[j] = old S[n], advance n
        S_PA,    // byte after a schedule: read S[i+1]
        S_PB,    // byte: update j, read S[j]
        S_PC,    // byte: write S[i] = S[j]
        S_PD,    // byte: write S[j] = old S[i], read keystream entry
        S_PE     // byte: deliver result into the output register
    } t_state;

    t_state             r_state;
    logic [BYTE_W-1:0]  r_key [KEY_LEN];
    logic [AW-1:0]      r_i;
    logic [AW-1:0]      r_j;
    logic [AW-1:0]      r_n;
    logic [KW-1:0]      r_k;
    logic [BYTE_W-1:0]  r_si;
    logic [BYTE_W-1:0]  r_sj;
    logic [AW-1:0]      r_t;
    logic               r_byp;
    logic               r_pend;
    logic [BYTE_W-1:0]  r_din;
    logic               r_last;
    logic               r_ovalid;
    t_out_beat          r_out;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;

    logic [AW-1:0]      n_i;
    logic [AW-1:0]      n_jk;
    logic [AW-1:0]      n_jp;
    logic [AW-1:0]      n_t;
    logic [BYTE_W-1:0]  keystream;
    logic               in_acc;
    logic               out_free;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The block takes a beat only while idle; a waiting result sits in the
    // output register, so a new beat can come in before it is taken.
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_ovalid || i_ready;

    // Index arithmetic. All sums wrap at 256 through the 8-bit width.
    assign n_i  = r_i + AW'(1);
    assign n_jk = r_j + ram_rdata + r_key[r_k];
    assign n_jp = r_j + ram_rdata;
    assign n_t  = r_si + r_sj;

    // If the keystream entry is the one written in S_PD, the RAM returned its
    // old contents on that read; the new value is the saved S[i].
    assign keystream = r_byp ? r_si : ram_rdata;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_n;
        ram_wdata = ram_rdata;
        ram_raddr = r_n;
        case (r_state)
            S_IDLE: begin
                ram_raddr = n_i;
            end
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_n;
                ram_wdata = r_n;
            end
            S_KA: begin
                ram_raddr = r_n;
            end
            S_KB: begin
                ram_raddr = n_jk;
            end
            S_KC: begin
                ram_we    = 1'b1;
                ram_waddr = r_n;
                ram_wdata = ram_rdata;
            end
            S_KD: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_si;
            end
            S_PA: begin
                ram_raddr = n_i;
            end
            S_PB: begin
                ram_raddr = n_jp;
            end
            S_PC: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = ram_rdata;
            end
            S_PD: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_si;
                ram_raddr = n_t;
            end
            S_PE: begin
                // Hold the read address so the data stays valid while the
                // output register is still occupied.
                ram_raddr = r_t;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Configuration writes land in the key bytes that the key length uses.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < KEY_LEN; b++) begin
                r_key[b] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEY_LOW: begin
                    for (int b = 0; b < KEY_LEN && b < 8; b++) begin
                        r_key[b] <= i_cfg_data[8*b +: 8];
                    end
                end
                CFG_KEY_HIGH: begin
                    for (int b = 8; b < KEY_LEN; b++) begin
                        r_key[b] <= i_cfg_data[8*(b-8) +: 8];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer state, indices and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_n      <= '0;
            r_k      <= '0;
            r_pend   <= 1'b1;
            r_ovalid <= 1'b0;
            r_out    <= '0;
        end else begin
            // A new result may replace one that leaves in the same cycle.
            if (r_state == S_PE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_din  <= i_in.data_in;
                        r_last <= i_in.last_in;
                        if (r_pend) begin
                            r_n     <= '0;
                            r_k     <= '0;
                            r_j     <= '0;
                            r_state <= S_INIT;
                        end else begin
                            r_i     <= n_i;
                            r_state <= S_PB;
                        end
                    end
                end
                S_INIT: begin
                    r_n <= r_n + AW'(1);
                    if (r_n == AW'(SBOX_DEPTH - 1)) begin
                        r_state <= S_KA;
                    end
                end
                S_KA: begin
                    r_state <= S_KB;
                end
                S_KB: begin
                    r_si    <= ram_rdata;
                    r_j     <= n_jk;
                    r_state <= S_KC;
                end
                S_KC: begin
                    r_state <= S_KD;
                end
                S_KD: begin
                    r_n <= r_n + AW'(1);
                    r_k <= (r_k == KW'(KEY_LEN - 1)) ? '0 : r_k + KW'(1);
                    if (r_n == AW'(SBOX_DEPTH - 1)) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_PA;
                    end else begin
                        r_state <= S_KA;
                    end
                end
                S_PA: begin
                    r_i     <= n_i;
                    r_state <= S_PB;
                end
                S_PB: begin
                    r_si    <= ram_rdata;
                    r_j     <= n_jp;
                    r_state <= S_PC;
                end
                S_PC: begin
                    r_sj    <= ram_rdata;
                    r_state <= S_PD;
                end
                S_PD: begin
                    r_t     <= n_t;
                    r_byp   <= (n_t == r_j);
                    r_state <= S_PE;
                end
                S_PE: begin
                    if (out_free) begin
                        r_out.data_out <= r_din ^ keystream;
                        r_out.last_out <= r_last;
                        if (r_last) begin
                            r_pend <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    // A beat that finds the schedule armed must start with the identity fill.
    a_sched_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_pend) |=> (r_state == S_INIT))
        else $error("key schedule did not start on a pending beat");

    // A result only appears out of the delivery state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_PE))
        else $error("output loaded outside the delivery state");

    // The S-box is never written while the block waits for a beat.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("S-box written while idle");

    // Keystream generation after a schedule starts from cleared indices.
    a_index_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PA) |-> (r_i == '0 && r_j == '0 && !r_pend))
        else $error("indices not cleared after key schedule");

endmodule

// ===== hdl/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed. Read during a write returns old data.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/rc4_stream_cipher_unit_tb.sv =====
// Self-checking testbench for rc4_stream_cipher_unit: drives key writes and data beats, and
// predicts every output beat with an RC4 shadow kept in a small scoreboard class.
// Depends on rc4_pkg for the beat structs and register indexes, and on the unit itself.
module rc4_stream_cipher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rc4_pkg::*;

    // A run where every beat ends a buffer pays the full key schedule per beat, plus sender
    // gaps and receiver stalls; 700 such beats stay well inside this.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int          MAX_REPORTS = 10;

    // Scoreboard: a shadow RC4 state that turns each accepted input beat into the
    // output beat the unit must produce, and checks the outputs in order.
    class rc4_cipher_shadow;
        t_out_beat      expected_q[$];
        logic [7:0]     perm[256];
        logic [7:0]     idx_i;
        logic [7:0]     idx_j;
        logic [63:0]    key_lo;
        logic [63:0]    key_hi;
        bit             rekey_due;
        int unsigned    failures;

        function new();
            foreach (perm[n]) perm[n] = 8'd0;
            idx_i     = 8'd0;
            idx_j     = 8'd0;
            key_lo    = 64'd0;
            key_hi    = 64'd0;
            rekey_due = 1'b1;
            failures  = 0;
        endfunction

        function void set_key(t_cfg_idx idx, logic [63:0] value);
            case (idx)
                CFG_KEY_LOW:  key_lo = value;
                CFG_KEY_HIGH: key_hi = value;
                default: ;
            endcase
        endfunction

        function logic [7:0] key_at(int n);
            int k;
            k = n % KEY_BYTES;
            if (k < 8) return key_lo[8*k +: 8];
            return key_hi[8*(k-8) +: 8];
        endfunction

        function void run_schedule();
            logic [7:0] j;
            logic [7:0] t;
            for (int n = 0; n < SBOX_DEPTH; n++) perm[n] = n[7:0];
            j = 8'd0;
            for (int n = 0; n < SBOX_DEPTH; n++) begin
                j       = j + perm[n] + key_at(n);
                t       = perm[n];
                perm[n] = perm[j];
                perm[j] = t;
            end
            idx_i     = 8'd0;
            idx_j     = 8'd0;
            rekey_due = 1'b0;
        endfunction

        function void note_input(t_in_beat beat);
            logic [7:0] t;
            logic [7:0] sum;
            t_out_beat  res;
            if (rekey_due) run_schedule();
            idx_i       = idx_i + 8'd1;
            idx_j       = idx_j + perm[idx_i];
            t           = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = t;
            sum         = perm[idx_i] + perm[idx_j];
            res.data_out = beat.data_in ^ perm[sum];
            res.last_out = beat.last_in;
            expected_q.push_back(res);
            if (beat.last_in) rekey_due = 1'b1;
        endfunction

        function void check_output(t_out_beat got);
            t_out_beat want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("Output beat with nothing expected: data %02h last %0d",
                             got.data_out, got.last_out);
                return;
            end
            want = expected_q.pop_front();
            if (got.data_out !== want.data_out || got.last_out !== want.last_out) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("Mismatch at %0t: data exp %02h got %02h, last exp %0d got %0d",
                             $realtime, want.data_out, got.data_out,
                             want.last_out, got.last_out);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    t_in_beat    i_in        = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    t_out_beat   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index = CFG_KEY_LOW;
    logic [63:0] i_cfg_data  = 64'd0;

    rc4_cipher_shadow shadow = new();

    // Idle percentages for the two sides; changed between phases.
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_count    = 0;
    // Beats still to go in the current random buffer; zero means a new buffer starts.
    int          buf_left       = 0;

    always #10 i_clk = ~i_clk;

    rc4_stream_cipher_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Watchdog: a hung handshake or a lost beat ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Output side: values seen here are the ones from before the edge, so a beat
    // counts exactly when valid and ready were both high in the last cycle.
    // Ready is redrawn every cycle at the current stall rate.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) shadow.check_output(o_out);
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Writes both key registers back to back; valid stays high across the pair.
    task automatic write_key(logic [63:0] lo, logic [63:0] hi);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_KEY_LOW;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow.set_key(CFG_KEY_LOW, lo);
        i_cfg_index <= CFG_KEY_HIGH;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow.set_key(CFG_KEY_HIGH, hi);
        i_cfg_valid <= 1'b0;
    endtask

    // Presents one data beat after an optional random gap and waits for it to be taken.
    // Valid is left high afterwards so back-to-back beats never drop it in between.
    task automatic send_byte(logic [7:0] data, logic last);
        t_in_beat beat;
        beat.data_in = data;
        beat.last_in = last;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= beat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        shadow.note_input(beat);
    endtask

    // Stops sending and waits until every predicted beat has come back, then lets the
    // pipeline settle so the unit is quiet.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Random buffers: mostly short, some single beats, a few long ones. The last
    // flag falls on the final beat of each buffer, so the key schedule reruns often.
    task automatic random_phase(int n_beats, int idle_pct, int stall_pct);
        int r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < n_beats; n++) begin
            if (buf_left == 0) begin
                r = $urandom_range(99);
                if (r < 10) buf_left = 1;
                else if (r < 85) buf_left = $urandom_range(24, 2);
                else buf_left = $urandom_range(80, 25);
            end
            // Halfway through, the sender holds off until the unit has caught up.
            if (n == n_beats / 2) drain();
            send_byte(8'($urandom_range(255)), buf_left == 1);
            buf_left--;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling: a familiar ascending key, data extremes in a
        // five-beat buffer, then a one-beat buffer.
        write_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        // Key of all ones, then the all-zero key.
        drain();
        write_key('1, '1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        drain();
        write_key('0, '0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        // Key changed while a buffer is open: the running keystream must carry on
        // and the new key shows only after the buffer ends.
        send_byte(8'h3c, 1'b0);
        send_byte(8'hc3, 1'b0);
        drain();
        write_key(64'h0123456789abcdef, 64'hfedcba9876543210);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hfe, 1'b0);
        send_byte(8'h01, 1'b1);

        // Random phases, with a fresh key at each boundary; buffers may stay open
        // across a key write.
        drain();
        write_key({$urandom, $urandom}, {$urandom, $urandom});
        random_phase(158, 0, 0);
        drain();
        write_key('1, {$urandom, $urandom});
        random_phase(158, 70, 0);
        drain();
        write_key({$urandom, $urandom}, '0);
        random_phase(158, 0, 70);
        drain();
        write_key({$urandom, $urandom}, {$urandom, $urandom});
        random_phase(158, 34, 34);

        // Close the final buffer cleanly, then let the output side empty out.
        if (buf_left != 0) send_byte(8'($urandom_range(255)), 1'b1);
        drain();
        repeat (20) @(posedge i_clk);

        if (shadow.failures == 0 && shadow.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
